// ----- sv/keypad_wavetable_generator_defines.svh -----
// assertion macros shared by the keypad wavetable generator checkers
// each macro expects clk and rst_n to be visible at the point of use
`ifndef KEYPAD_WAVETABLE_GENERATOR_DEFINES_SVH
`define KEYPAD_WAVETABLE_GENERATOR_DEFINES_SVH

// same-cycle implication
`define KWG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KWG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/kwg_pkg.sv -----
// shared types, codes and waveform tables for the keypad wavetable generator
// no dependencies
`default_nettype none

package kwg_pkg;

  localparam int TABLE_LEN_DEF = 30;
  localparam int WAVE_ROM_LEN  = 30;
  localparam int IDX_W         = 5;

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_SCAN = 2'd1;
  localparam logic [1:0] REQ_KEY  = 2'd2;

  // digit entry phases
  localparam logic [1:0] PH_TENS    = 2'd0;
  localparam logic [1:0] PH_UNITS   = 2'd1;
  localparam logic [1:0] PH_CONFIRM = 2'd2;

  // waveform selections
  localparam logic [1:0] WAVE_SINE = 2'd0;
  localparam logic [1:0] WAVE_SAW  = 2'd1;
  localparam logic [1:0] WAVE_TRI  = 2'd2;

  // row patterns of a single pressed key, active low
  localparam logic [3:0] ROW_0 = 4'h7;
  localparam logic [3:0] ROW_1 = 4'hB;
  localparam logic [3:0] ROW_2 = 4'hD;
  localparam logic [3:0] ROW_3 = 4'hE;

  localparam logic [4:0] KEY_ZERO    = 5'd10;
  localparam logic [4:0] KEY_WAVE_LO = 5'd11;
  localparam logic [4:0] KEY_WAVE_HI = 5'd13;
  localparam logic [4:0] KEY_IGN_HI  = 5'd15;
  localparam logic [4:0] KEY_ENTER   = 5'd16;

  localparam logic [7:0]  DEFAULT_FREQ = 8'd100;
  localparam logic [11:0] TICKS_RST    = 12'd100;
  localparam logic [11:0] PERIOD_RST   = 12'd253;
  localparam logic [11:0] PERIOD_MAX   = 12'hFFF;

  // period = round(33333.33 / f) - 90, as (3333333 + 50 f) / (100 f) - 90
  localparam int          NUM_W       = 22;
  localparam int          DEN_W       = 15;
  localparam logic [21:0] PERIOD_NUM  = 22'd3333333;
  localparam logic [21:0] NUM_SCALE   = 22'd50;
  localparam logic [14:0] DEN_SCALE   = 15'd100;
  localparam logic [21:0] PERIOD_OFFS = 22'd90;
  localparam int          DIV_STEPS   = NUM_W / 2;
  localparam int          DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [7:0] SINE_ROM [WAVE_ROM_LEN] = '{
    8'd128, 8'd154, 8'd180, 8'd203, 8'd223, 8'd238, 8'd249, 8'd255, 8'd255, 8'd249,
    8'd238, 8'd223, 8'd203, 8'd180, 8'd154, 8'd128, 8'd101, 8'd75,  8'd52,  8'd32,
    8'd17,  8'd6,   8'd0,   8'd0,   8'd6,   8'd17,  8'd32,  8'd52,  8'd75,  8'd101
  };
  localparam logic [7:0] SAW_ROM [WAVE_ROM_LEN] = '{
    8'd0,   8'd8,   8'd17,  8'd26,  8'd35,  8'd43,  8'd52,  8'd61,  8'd70,  8'd79,
    8'd87,  8'd96,  8'd105, 8'd114, 8'd123, 8'd131, 8'd140, 8'd149, 8'd158, 8'd167,
    8'd175, 8'd184, 8'd193, 8'd202, 8'd211, 8'd219, 8'd228, 8'd237, 8'd246, 8'd255
  };
  localparam logic [7:0] TRI_ROM [WAVE_ROM_LEN] = '{
    8'd0,   8'd17,  8'd34,  8'd51,  8'd68,  8'd85,  8'd102, 8'd119, 8'd136, 8'd153,
    8'd170, 8'd187, 8'd204, 8'd221, 8'd238, 8'd255, 8'd238, 8'd221, 8'd204, 8'd187,
    8'd170, 8'd153, 8'd136, 8'd119, 8'd102, 8'd85,  8'd68,  8'd51,  8'd34,  8'd17
  };

  function automatic logic [7:0] rom_sample(input logic [1:0] sel, input logic [IDX_W-1:0] idx);
    logic [7:0] s;
    if (32'(idx) >= WAVE_ROM_LEN) begin
      s = 8'd0;
    end else if (sel == WAVE_SAW) begin
      s = SAW_ROM[idx];
    end else if (sel == WAVE_TRI) begin
      s = TRI_ROM[idx];
    end else begin
      s = SINE_ROM[idx];
    end
    return s;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic apply;
    logic div_step;
    logic div_finish;
    logic load_out;
  } kwg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } kwg_sts_t;

endpackage

`default_nettype wire

// ----- sv/kwg_ctrl.sv -----
// sequencing controller: accept, divide, finish, hand result to output register
// depends on kwg_pkg
`default_nettype none

module kwg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire kwg_pkg::kwg_sts_t sts,
  output kwg_pkg::kwg_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_PEND = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.apply = 1'b1;
          state_nxt = sts.need_div ? ST_DIV : ST_PEND;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.div_finish = 1'b1;
        state_nxt      = ST_PEND;
      end
      ST_PEND: begin
        // result waits here until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- sv/kwg_dpath.sv -----
// datapath: generator state, key decode, radix-4 period divider, output register
// depends on kwg_pkg
`default_nettype none

module kwg_dpath #(
  parameter int TABLE_LEN = kwg_pkg::TABLE_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [3:0]        in_row_bits,
  input  wire kwg_pkg::kwg_cmd_t cmd,
  output kwg_pkg::kwg_sts_t      sts,
  output logic [7:0]             out_duty,
  output logic [3:0]             out_column_drive,
  output logic [1:0]             out_entry_phase,
  output logic [1:0]             out_wave_choice,
  output logic [11:0]            out_period_ticks
);

  localparam int LAST_IDX = TABLE_LEN - 1;
  localparam int IW       = kwg_pkg::IDX_W;
  localparam int NW       = kwg_pkg::NUM_W;
  localparam int DW       = kwg_pkg::DEN_W;
  localparam int CW       = kwg_pkg::DIV_CNT_W;

  // generator state
  logic [IW-1:0] idx_r, idx_nxt;
  logic [1:0]    wsel_r, wsel_nxt;
  logic [11:0]   ticks_r, ticks_nxt;
  logic [11:0]   period_r, period_nxt;
  logic [7:0]    duty_r, duty_nxt;
  logic [1:0]    col_r, col_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    partial_r, partial_nxt;

  // divider
  logic [NW-1:0] num_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;

  // output register
  logic [7:0]  o_duty_r;
  logic [3:0]  o_col_r;
  logic [1:0]  o_phase_r;
  logic [1:0]  o_wave_r;
  logic [11:0] o_period_r;

  logic          row_hit;
  logic [4:0]    row_base;
  logic [4:0]    key;
  logic          wave_key;
  logic [7:0]    f_sel;
  logic          confirm;
  logic          q_hi, q_lo;
  logic [DW-1:0] rem_a, rem_b;
  logic [NW-1:0] quo_diff;
  logic [11:0]   period_sat;

  // one restoring division step
  function automatic logic [DW:0] div_bit(input logic [DW-1:0] rem, input logic nbit,
                                          input logic [DW-1:0] den);
    logic [DW:0] sh;
    logic [DW:0] res;
    sh = {rem, nbit};
    if (sh >= {1'b0, den}) begin
      res = {1'b1, DW'(sh - {1'b0, den})};
    end else begin
      res = {1'b0, sh[DW-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    row_hit  = 1'b1;
    row_base = 5'd0;
    unique case (in_row_bits)
      kwg_pkg::ROW_0: row_base = 5'd0;
      kwg_pkg::ROW_1: row_base = 5'd4;
      kwg_pkg::ROW_2: row_base = 5'd8;
      kwg_pkg::ROW_3: row_base = 5'd12;
      default:        row_hit  = 1'b0;
    endcase
  end

  assign key      = row_base + {3'b000, col_r} + 5'd1;
  assign wave_key = (key >= kwg_pkg::KEY_WAVE_LO) && (key <= kwg_pkg::KEY_IGN_HI);
  assign f_sel    = (key == kwg_pkg::KEY_ENTER) ? partial_r : kwg_pkg::DEFAULT_FREQ;
  assign confirm  = (in_req_type == kwg_pkg::REQ_KEY) && row_hit && !wave_key &&
                    (phase_r != kwg_pkg::PH_TENS) && (phase_r != kwg_pkg::PH_UNITS);

  assign sts.need_div = confirm && (f_sel != 8'd0);
  assign sts.div_last = (cnt_r == CW'(kwg_pkg::DIV_STEPS - 1));

  // two quotient bits per cycle
  assign {q_hi, rem_a} = div_bit(rem_r, num_r[NW-1], den_r);
  assign {q_lo, rem_b} = div_bit(rem_a, num_r[NW-2], den_r);

  // clamp quotient minus offset into 0..4095
  always_comb begin
    quo_diff = quo_r - kwg_pkg::PERIOD_OFFS;
    if (quo_r < kwg_pkg::PERIOD_OFFS) begin
      period_sat = 12'd0;
    end else if (quo_diff > NW'(kwg_pkg::PERIOD_MAX)) begin
      period_sat = kwg_pkg::PERIOD_MAX;
    end else begin
      period_sat = quo_diff[11:0];
    end
  end

  always_comb begin
    idx_nxt     = idx_r;
    wsel_nxt    = wsel_r;
    ticks_nxt   = ticks_r;
    period_nxt  = period_r;
    duty_nxt    = duty_r;
    col_nxt     = col_r;
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    if (cmd.apply) begin
      case (in_req_type)
        kwg_pkg::REQ_TICK: begin
          if (ticks_r <= 12'd1) begin
            if (32'(idx_r) >= LAST_IDX) begin
              idx_nxt = '0;
            end else begin
              idx_nxt = idx_r + IW'(1);
            end
            duty_nxt  = kwg_pkg::rom_sample(wsel_r, idx_nxt);
            ticks_nxt = period_r;
          end else begin
            ticks_nxt = ticks_r - 12'd1;
          end
        end
        kwg_pkg::REQ_SCAN: col_nxt = col_r + 2'd1;
        kwg_pkg::REQ_KEY: begin
          if (row_hit) begin
            if (wave_key) begin
              if (key <= kwg_pkg::KEY_WAVE_HI) begin
                wsel_nxt = 2'(key - kwg_pkg::KEY_WAVE_LO);
              end
            end else begin
              case (phase_r)
                kwg_pkg::PH_TENS: begin
                  partial_nxt = {3'b000, key} * 8'd10;
                  phase_nxt   = kwg_pkg::PH_UNITS;
                end
                kwg_pkg::PH_UNITS: begin
                  partial_nxt = partial_r +
                                ((key == kwg_pkg::KEY_ZERO) ? 8'd0 : {3'b000, key});
                  phase_nxt   = kwg_pkg::PH_CONFIRM;
                end
                default: begin
                  phase_nxt = kwg_pkg::PH_TENS;
                  idx_nxt   = '0;
                  // zero frequency skips the divider
                  if (f_sel == 8'd0) begin
                    period_nxt = kwg_pkg::PERIOD_MAX;
                  end
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd.div_finish) begin
      period_nxt = period_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      wsel_r    <= kwg_pkg::WAVE_SAW;
      ticks_r   <= kwg_pkg::TICKS_RST;
      period_r  <= kwg_pkg::PERIOD_RST;
      duty_r    <= 8'd0;
      col_r     <= 2'd0;
      phase_r   <= kwg_pkg::PH_TENS;
      partial_r <= 8'd0;
      cnt_r     <= '0;
    end else begin
      idx_r     <= idx_nxt;
      wsel_r    <= wsel_nxt;
      ticks_r   <= ticks_nxt;
      period_r  <= period_nxt;
      duty_r    <= duty_nxt;
      col_r     <= col_nxt;
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      if (cmd.apply) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      num_r <= kwg_pkg::PERIOD_NUM + NW'(f_sel) * kwg_pkg::NUM_SCALE;
      den_r <= DW'(f_sel) * kwg_pkg::DEN_SCALE;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NW-3:0], 2'b00};
      quo_r <= {quo_r[NW-3:0], q_hi, q_lo};
      rem_r <= rem_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_duty_r   <= duty_r;
      o_col_r    <= ~(4'b0001 << col_r);
      o_phase_r  <= phase_r;
      o_wave_r   <= wsel_r;
      o_period_r <= period_r;
    end
  end

  assign out_duty         = o_duty_r;
  assign out_column_drive = o_col_r;
  assign out_entry_phase  = o_phase_r;
  assign out_wave_choice  = o_wave_r;
  assign out_period_ticks = o_period_r;

endmodule

`default_nettype wire

// ----- sv/keypad_wavetable_generator.sv -----
// keypad wavetable generator: one result per transfer, showing state after the event
// an event is applied on the input transfer, then waits in the pending state for the
//   output register; a frequency confirm first runs the divider at two quotient bits per
//   step, then a finish step; the input stalls until the result is in the output register
// reset: synchronous active-low rst_n restores the power-up waveform state, no clearing pass
// depends on kwg_pkg, kwg_ctrl, kwg_dpath
`default_nettype none

module keypad_wavetable_generator #(
  parameter int TABLE_LEN = kwg_pkg::TABLE_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [3:0]  in_row_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_duty,
  output logic [3:0]       out_column_drive,
  output logic [1:0]       out_entry_phase,
  output logic [1:0]       out_wave_choice,
  output logic [11:0]      out_period_ticks
);

  kwg_pkg::kwg_cmd_t cmd;
  kwg_pkg::kwg_sts_t sts;

  kwg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kwg_dpath #(
    .TABLE_LEN (TABLE_LEN)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req_type      (in_req_type),
    .in_row_bits      (in_row_bits),
    .cmd              (cmd),
    .sts              (sts),
    .out_duty         (out_duty),
    .out_column_drive (out_column_drive),
    .out_entry_phase  (out_entry_phase),
    .out_wave_choice  (out_wave_choice),
    .out_period_ticks (out_period_ticks)
  );

endmodule

`default_nettype wire

// ----- sv/kwg_checker.sv -----
// port-level checks for the keypad wavetable generator, bound to the top level
// depends on keypad_wavetable_generator_defines.svh
`default_nettype none
`include "keypad_wavetable_generator_defines.svh"

module kwg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_duty,
  input wire logic [3:0]  out_column_drive,
  input wire logic [1:0]  out_entry_phase,
  input wire logic [1:0]  out_wave_choice,
  input wire logic [11:0] out_period_ticks
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // a stalled result holds
  `KWG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_duty) && $stable(out_column_drive) && $stable(out_period_ticks), "stalled result changed")

  // exactly one column driven low
  `KWG_ASSERT_IMP(a_col_onehot, out_valid, $onehot(~out_column_drive), "column drive not one-hot low")

  // phase and waveform stay in their ranges
  `KWG_ASSERT_IMP(a_codes, out_valid, (out_entry_phase != 2'd3) && (out_wave_choice != 2'd3), "phase or waveform code out of range")

  // an accepted event leaves the input side busy in the following cycle
  `KWG_ASSERT_NXT(a_busy_after_xfer, in_xfer, in_stall, "input taken again without a processing cycle")

endmodule

bind keypad_wavetable_generator kwg_checker u_kwg_checker (.*);

`default_nettype wire

// ----- tb/sv/keypad_wavetable_generator_test.sv -----
// self-checking testbench for keypad_wavetable_generator: directed and random events
// are predicted by a scoreboard and each transfer on the result side is compared field by field
// depends on kwg_pkg and the generator RTL
module keypad_wavetable_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kwg_pkg::*;

  localparam int         TABLE_LEN       = TABLE_LEN_DEF;
  localparam logic [1:0] REQ_NONE        = 2'd3;
  localparam int         RANDOM_ITEMS    = 750;
  localparam int         HOLD_OFF_AFTER  = 200;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         DRAIN_CYCLES    = 40;
  localparam int         CYCLE_LIMIT     = 1_000_000;

  typedef struct packed {
    logic [7:0]  duty;
    logic [3:0]  column_drive;
    logic [1:0]  entry_phase;
    logic [1:0]  wave_choice;
    logic [11:0] period_ticks;
  } wave_status_t;

  class wavegen_scoreboard;
    logic [4:0]  idx;
    logic [1:0]  wave;
    logic [11:0] ticks_left;
    logic [11:0] period;
    logic [7:0]  duty;
    logic [1:0]  column;
    logic [1:0]  phase;
    logic [7:0]  partial_freq;
    wave_status_t pending_status[$];
    int errors;
    int checked;
    int fires;
    int confirms;
    int wave_changes;

    function new();
      idx          = '0;
      wave         = WAVE_SAW;
      ticks_left   = TICKS_RST;
      period       = PERIOD_RST;
      duty         = '0;
      column       = '0;
      phase        = PH_TENS;
      partial_freq = '0;
      errors       = 0;
      checked      = 0;
      fires        = 0;
      confirms     = 0;
      wave_changes = 0;
    endfunction

    function logic [7:0] table_sample(logic [1:0] sel, logic [4:0] i);
      if (int'(i) >= WAVE_ROM_LEN) return 8'd0;
      case (sel)
        WAVE_SAW: return SAW_ROM[i];
        WAVE_TRI: return TRI_ROM[i];
        default:  return SINE_ROM[i];
      endcase
    endfunction

    // rounded 33333.33 / f less the fixed offset, clamped to the counter width
    function logic [11:0] period_for(int unsigned f);
      int unsigned q;
      if (f == 0) return PERIOD_MAX;
      q = (PERIOD_NUM + NUM_SCALE * f) / (DEN_SCALE * f);
      if (q < PERIOD_OFFS) return '0;
      q = q - PERIOD_OFFS;
      return (q > PERIOD_MAX) ? PERIOD_MAX : 12'(q);
    endfunction

    function void timer_tick();
      if (ticks_left <= 12'd1) begin
        idx        = (int'(idx) >= TABLE_LEN - 1) ? 5'd0 : idx + 5'd1;
        duty       = table_sample(wave, idx);
        ticks_left = period;
        fires++;
      end else begin
        ticks_left = ticks_left - 12'd1;
      end
    endfunction

    function void key_edge(logic [3:0] rows);
      logic [4:0] base;
      logic [4:0] key;
      case (rows)
        ROW_0:   base = 5'd0;
        ROW_1:   base = 5'd4;
        ROW_2:   base = 5'd8;
        ROW_3:   base = 5'd12;
        default: return;
      endcase
      key = base + 5'(column) + 5'd1;
      if (key >= KEY_WAVE_LO && key <= KEY_IGN_HI) begin
        if (key <= KEY_WAVE_HI) begin
          wave = 2'(key - KEY_WAVE_LO);
          wave_changes++;
        end
        return;
      end
      case (phase)
        PH_TENS: begin
          partial_freq = 8'(int'(key) * 10);
          phase        = PH_UNITS;
        end
        PH_UNITS: begin
          partial_freq = partial_freq + ((key == KEY_ZERO) ? 8'd0 : 8'(key));
          phase        = PH_CONFIRM;
        end
        default: begin
          // any third key other than enter falls back to the default frequency
          period = period_for(32'((key == KEY_ENTER) ? partial_freq : DEFAULT_FREQ));
          phase  = PH_TENS;
          idx    = '0;
          confirms++;
        end
      endcase
    endfunction

    function void note_event(logic [1:0] req, logic [3:0] rows);
      wave_status_t s;
      case (req)
        REQ_TICK: timer_tick();
        REQ_SCAN: column = column + 2'd1;
        REQ_KEY:  key_edge(rows);
        default: ;
      endcase
      s.duty         = duty;
      s.column_drive = ~(4'b0001 << column);
      s.entry_phase  = phase;
      s.wave_choice  = wave;
      s.period_ticks = period;
      pending_status.push_back(s);
    endfunction

    function void mismatch(string field, logic [11:0] want, logic [11:0] got);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(wave_status_t got);
      wave_status_t want;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, duty %0d period %0d",
                 $time, got.duty, got.period_ticks);
        return;
      end
      want = pending_status.pop_front();
      checked++;
      if (got.duty !== want.duty) mismatch("duty", 12'(want.duty), 12'(got.duty));
      if (got.column_drive !== want.column_drive)
        mismatch("column_drive", 12'(want.column_drive), 12'(got.column_drive));
      if (got.entry_phase !== want.entry_phase)
        mismatch("entry_phase", 12'(want.entry_phase), 12'(got.entry_phase));
      if (got.wave_choice !== want.wave_choice)
        mismatch("wave_choice", 12'(want.wave_choice), 12'(got.wave_choice));
      if (got.period_ticks !== want.period_ticks)
        mismatch("period_ticks", want.period_ticks, got.period_ticks);
    endfunction
  endclass

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic [1:0]  in_req_type      = REQ_TICK;
  logic [3:0]  in_row_bits      = 4'h0;
  logic        out_stall        = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_duty;
  logic [3:0]  out_column_drive;
  logic [1:0]  out_entry_phase;
  logic [1:0]  out_wave_choice;
  logic [11:0] out_period_ticks;

  wavegen_scoreboard sb = new();
  int items_sent  = 0;
  int cycle_count = 0;
  bit quiet       = 1'b0;

  keypad_wavetable_generator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_row_bits      (in_row_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty         (out_duty),
    .out_column_drive (out_column_drive),
    .out_entry_phase  (out_entry_phase),
    .out_wave_choice  (out_wave_choice),
    .out_period_ticks (out_period_ticks)
  );

  initial forever #1 clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(input logic [1:0] req, input logic [3:0] rows);
    int gap;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_row_bits <= rows;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_event(req, rows);
    items_sent++;
    gap = quiet ? 0 : pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // scan until the key's column is driven, then send its row edge
  task automatic press_key(input int k);
    logic [3:0] rows;
    logic [1:0] col;
    col = 2'((k - 1) % 4);
    case ((k - 1) / 4)
      0:       rows = ROW_0;
      1:       rows = ROW_1;
      2:       rows = ROW_2;
      default: rows = ROW_3;
    endcase
    while (sb.column != col) send(REQ_SCAN, 4'($urandom));
    send(REQ_KEY, rows);
  endtask

  function automatic int digit_key();
    int k;
    k = $urandom_range(0, 10);
    return (k == 0) ? int'(KEY_ENTER) : k;
  endfunction

  task automatic enter_frequency();
    press_key(digit_key());
    press_key(digit_key());
    press_key(($urandom_range(0, 3) != 0) ? int'(KEY_ENTER) : $urandom_range(1, 10));
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(wave_status_t'{out_duty, out_column_drive, out_entry_phase,
                                     out_wave_choice, out_period_ticks});
  end

  // result side: random stalls, one long hold-off so the block backs up into its input
  initial begin
    int stall_len;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && items_sent >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall_len = pick_pause();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6))
        @(posedge clk);
    end
  end

  initial begin
    int directed_items;
    int pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send(REQ_NONE, 4'hF);
    send(REQ_TICK, 4'h0);
    send(REQ_KEY, 4'hF);             // no row pulled low
    send(REQ_KEY, 4'h0);             // every row low at once
    for (int k = int'(KEY_WAVE_LO); k <= int'(KEY_IGN_HI); k++) press_key(k);
    press_key(1);
    press_key(int'(KEY_ZERO));
    press_key(int'(KEY_ENTER));      // lowest frequency, longest period
    repeat (3) press_key(int'(KEY_ENTER)); // highest frequency, shortest period
    press_key(5);
    press_key(9);
    press_key(2);                    // third key is not enter
    directed_items = items_sent;

    while (items_sent < directed_items + RANDOM_ITEMS) begin
      if ($urandom_range(0, 59) == 0) quiet = ~quiet;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 25)) send(REQ_TICK, 4'($urandom));
      end else if (pick < 60) begin
        enter_frequency();
      end else if (pick < 70) begin
        press_key($urandom_range(int'(KEY_WAVE_LO), int'(KEY_IGN_HI)));
      end else if (pick < 80) begin
        send(REQ_SCAN, 4'($urandom));
      end else if (pick < 92) begin
        send(REQ_KEY, 4'($urandom));
      end else begin
        send(2'($urandom), 4'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: %0d samples played, %0d frequency confirms, %0d wave changes",
             sb.checked, sb.fires, sb.confirms, sb.wave_changes);
    $display("%0d mismatches over %0d cycles", sb.errors, cycle_count);
    if (sb.errors == 0 && sb.pending_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
